### design/ttw_pkg.sv
package ttw_pkg;

  localparam int unsigned OA_BITS_DEF = 48;
  localparam int unsigned BASE_W      = 48;
  localparam int unsigned CFG_DATA_W  = 48;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned SHIFT_W     = 6;
  localparam int unsigned IDX_W       = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRANULE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TXSZ       = 2'd2;

  localparam logic KIND_TRANSLATE = 1'b0;
  localparam logic KIND_RESPONSE  = 1'b1;
  localparam logic RES_READ       = 1'b0;
  localparam logic RES_DONE       = 1'b1;

  localparam logic [1:0] GRAN_4K  = 2'd0;
  localparam logic [1:0] GRAN_16K = 2'd1;
  localparam logic [1:0] GRAN_64K = 2'd2;

  localparam logic [5:0]        TXSZ_RESET = 6'd16;
  localparam logic [ADDR_W-1:0] FAULT_ADDR = 64'hffff_ffff_ffff_ffff;
  localparam logic [1:0]        LEVEL_LAST = 2'd3;

  typedef struct packed {
    logic [BASE_W-1:0] table_base;
    logic [1:0]        granule;
    logic [5:0]        txsz;
  } cfg_t;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] virtual_address;
    logic [ADDR_W-1:0] descriptor;
  } in_item_t;

  typedef struct packed {
    logic              result_kind;
    logic [ADDR_W-1:0] out_address;
    logic              fault;
    logic [1:0]        at_level;
  } res_t;

  function automatic logic [1:0] gran_code(input logic [1:0] granule);
    return granule[1] ? GRAN_64K : granule;
  endfunction

  function automatic logic [SHIFT_W-1:0] level_shift(input logic [1:0] g,
                                                     input logic [1:0] lvl);
    logic [SHIFT_W-1:0] page;
    logic [SHIFT_W-1:0] bits;
    logic [1:0]         rem;
    page = SHIFT_W'(12) + SHIFT_W'({g, 1'b0});
    bits = SHIFT_W'(9) + SHIFT_W'({g, 1'b0});
    rem  = LEVEL_LAST - lvl;
    return page + SHIFT_W'(bits * SHIFT_W'(rem));
  endfunction

  function automatic logic [IDX_W-1:0] index_mask(input logic [1:0] g);
    logic [IDX_W-1:0] m;
    case (g)
      GRAN_4K:  m = IDX_W'(13'h1ff);
      GRAN_16K: m = IDX_W'(13'h7ff);
      default:  m = IDX_W'(13'h1fff);
    endcase
    return m;
  endfunction

  function automatic logic [1:0] root_level(input logic [1:0] g, input logic [5:0] txsz);
    logic [6:0] width;
    logic [6:0] page;
    logic [6:0] step;
    logic [6:0] n;
    logic [1:0] lvl;
    width = 7'd64 - {1'b0, txsz};
    page  = 7'd12 + {4'd0, g, 1'b0};
    step  = 7'd9 + {4'd0, g, 1'b0};
    n     = width - page - 7'd1;
    if (width <= page) begin
      lvl = 2'd3;
    end else if (n >= 7'(step * 7'd3)) begin
      lvl = 2'd0;
    end else if (n >= 7'(step * 7'd2)) begin
      lvl = 2'd1;
    end else if (n >= step) begin
      lvl = 2'd2;
    end else begin
      lvl = 2'd3;
    end
    return lvl;
  endfunction

endpackage

### design/ttw_if.sv
interface ttw_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [ttw_pkg::ADDR_W-1:0]    virtual_address;
  logic [ttw_pkg::ADDR_W-1:0]    descriptor;

  modport source (output valid, kind, virtual_address, descriptor, input ready);
  modport sink (input valid, kind, virtual_address, descriptor, output ready);
endinterface

interface ttw_out_if;
  logic                          valid;
  logic                          ready;
  logic                          result_kind;
  logic [ttw_pkg::ADDR_W-1:0]    out_address;
  logic                          fault;
  logic [1:0]                    at_level;

  modport source (output valid, result_kind, out_address, fault, at_level, input ready);
  modport sink (input valid, result_kind, out_address, fault, at_level, output ready);
endinterface

### design/ttw_cfg_regs.sv
module ttw_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ttw_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ttw_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output ttw_pkg::cfg_t                    cfg_o
);

  ttw_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ttw_pkg::CFG_TABLE_BASE: cfg_d.table_base = cfg_data_i[ttw_pkg::BASE_W-1:0];
        ttw_pkg::CFG_GRANULE:    cfg_d.granule = cfg_data_i[1:0];
        ttw_pkg::CFG_TXSZ:       cfg_d.txsz = cfg_data_i[5:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.table_base <= '0;
      cfg_q.granule    <= ttw_pkg::GRAN_4K;
      cfg_q.txsz       <= ttw_pkg::TXSZ_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/ttw_walk_core.sv
module ttw_walk_core #(
  parameter int unsigned OaBits = ttw_pkg::OA_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ttw_pkg::cfg_t      cfg_i,
  input  ttw_pkg::in_item_t  item_i,
  input  logic               step_i,
  output logic               res_valid_o,
  output ttw_pkg::res_t      res_o
);

  localparam int unsigned TpW = (OaBits > ttw_pkg::BASE_W) ? OaBits : ttw_pkg::BASE_W;
  localparam logic [ttw_pkg::ADDR_W-1:0] OaMask =
    ((ttw_pkg::ADDR_W'(1) << OaBits) - ttw_pkg::ADDR_W'(1)) & ~ttw_pkg::ADDR_W'(12'hfff);

  logic                        walking_q, walking_d;
  logic [ttw_pkg::ADDR_W-1:0]  held_q, held_d;
  logic [1:0]                  level_q, level_d;
  logic [TpW-1:0]              tp_q, tp_d;

  logic [1:0]                  g;
  logic [ttw_pkg::ADDR_W-1:0]  oa;
  logic [ttw_pkg::SHIFT_W-1:0] cur_shift;
  logic [ttw_pkg::SHIFT_W-1:0] rd_shift;
  logic [ttw_pkg::IDX_W-1:0]   rd_idx;
  logic [ttw_pkg::ADDR_W-1:0]  rd_addr;
  logic [ttw_pkg::ADDR_W-1:0]  off_mask;
  logic                        emit_read;

  assign g         = ttw_pkg::gran_code(cfg_i.granule);
  assign oa        = item_i.descriptor & OaMask;
  assign cur_shift = ttw_pkg::level_shift(g, level_q);
  assign off_mask  = (ttw_pkg::ADDR_W'(1) << cur_shift) - ttw_pkg::ADDR_W'(1);

  always_comb begin
    walking_d   = walking_q;
    held_d      = held_q;
    level_d     = level_q;
    tp_d        = tp_q;
    emit_read   = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (item_i.kind == ttw_pkg::KIND_TRANSLATE) begin
      walking_d = 1'b1;
      held_d    = item_i.virtual_address;
      level_d   = ttw_pkg::root_level(g, cfg_i.txsz);
      tp_d      = TpW'(cfg_i.table_base);
      emit_read = 1'b1;
    end else if (walking_q) begin
      res_valid_o = 1'b1;
      if (!item_i.descriptor[0]) begin
        walking_d         = 1'b0;
        res_o.result_kind = ttw_pkg::RES_DONE;
        res_o.out_address = ttw_pkg::FAULT_ADDR;
        res_o.fault       = 1'b1;
        res_o.at_level    = level_q;
      end else if (!item_i.descriptor[1] || level_q == ttw_pkg::LEVEL_LAST) begin
        walking_d         = 1'b0;
        res_o.result_kind = ttw_pkg::RES_DONE;
        res_o.out_address = oa + (held_q & off_mask);
        res_o.fault       = 1'b0;
        res_o.at_level    = level_q;
      end else begin
        tp_d      = TpW'(oa);
        level_d   = level_q + 2'd1;
        emit_read = 1'b1;
      end
    end
    rd_shift = ttw_pkg::level_shift(g, level_d);
    rd_idx   = ttw_pkg::IDX_W'(held_d >> rd_shift) & ttw_pkg::index_mask(g);
    rd_addr  = ttw_pkg::ADDR_W'(tp_d) + ttw_pkg::ADDR_W'({rd_idx, 3'b000});
    if (emit_read) begin
      res_valid_o       = 1'b1;
      res_o.result_kind = ttw_pkg::RES_READ;
      res_o.out_address = rd_addr;
      res_o.fault       = 1'b0;
      res_o.at_level    = level_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walking_q <= 1'b0;
      held_q    <= '0;
      level_q   <= '0;
      tp_q      <= '0;
    end else if (step_i) begin
      walking_q <= walking_d;
      held_q    <= held_d;
      level_q   <= level_d;
      tp_q      <= tp_d;
    end
  end

endmodule

### design/translation_table_walker_unit.sv
// Translation table walker, lookup only, 64-bit descriptor format.
// Input channel in_i carries either a translate request (kind 0, virtual
// address) or a descriptor read response (kind 1, descriptor). Output
// channel out_o carries either a descriptor read request (result_kind 0,
// address and level) or a finished translation (result_kind 1, output
// address or all ones with fault set). A response while no walk is active
// gives no output; a request during a walk restarts it.
// The configuration port writes table base, granule and TxSZ; write it only
// while no walk traffic is in flight.
// A transfer accepted into the input register is decoded from it and lands
// in the output register, which drives out_o. Throughput: one item per
// cycle while the receiver does not stall, set by the single decode pass
// between input and output registers.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more item; in_i.ready falls only when
// both registers are full.
// Reset clears the walk state and loads the configuration reset values.
module translation_table_walker_unit #(
  parameter int unsigned OaBits = ttw_pkg::OA_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ttw_in_if.sink                          in_i,
  ttw_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [ttw_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ttw_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  ttw_pkg::cfg_t     cfg;
  ttw_pkg::in_item_t item_q;
  logic              item_valid_q;
  ttw_pkg::res_t     res;
  logic              res_valid;
  ttw_pkg::res_t     out_q;
  logic              out_valid_q;
  logic              out_space;
  logic              advance;

  ttw_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ttw_walk_core #(
    .OaBits (OaBits)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .item_i      (item_q),
    .step_i      (advance),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_space = !out_valid_q || out_o.ready;
  assign advance   = item_valid_q && (!res_valid || out_space);
  assign in_i.ready = !item_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      item_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.kind            <= in_i.kind;
      item_q.virtual_address <= in_i.virtual_address;
      item_q.descriptor      <= in_i.descriptor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_kind = out_q.result_kind;
  assign out_o.out_address = out_q.out_address;
  assign out_o.fault       = out_q.fault;
  assign out_o.at_level    = out_q.at_level;

endmodule

### verif/translation_table_walker_unit_test.sv
module translation_table_walker_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ttw_pkg::*;

  localparam logic [ADDR_W-1:0] OA_FIELD      = 64'h0000_ffff_ffff_f000;
  localparam logic [1:0]        GRAN_RESERVED = 2'd3;
  localparam int unsigned       RUN_LIMIT     = 500000;
  localparam int unsigned       PHASES        = 12;
  localparam int unsigned       PHASE_ITEMS   = 70;
  localparam int unsigned       MAX_PRINTS    = 40;

  typedef enum logic [1:0] {DESC_TABLE, DESC_BLOCK, DESC_INVALID} desc_form_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  ttw_in_if  walk_in ();
  ttw_out_if walk_out ();

  translation_table_walker_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (walk_in),
    .out_o      (walk_out),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #4ns clk_i = ~clk_i;

  // shadow of the block's registers and walk state
  logic [BASE_W-1:0] cfg_base = '0;
  logic [1:0]        cfg_gran = GRAN_4K;
  logic [5:0]        cfg_txsz = TXSZ_RESET;
  bit                walking = 1'b0;
  logic [ADDR_W-1:0] walk_va = '0;
  logic [1:0]        walk_lvl = '0;
  logic [ADDR_W-1:0] walk_table = '0;

  in_item_t    walk_items[$];
  res_t        walk_results[$];
  int unsigned drain_marks[$];
  in_item_t    on_wire;

  int unsigned queued = 0;
  int unsigned accepted = 0;
  int unsigned send_gap = 0;
  int unsigned take_stall = 0;
  int unsigned errors = 0;
  int unsigned checked = 0;
  int unsigned reads_seen = 0;
  int unsigned leaves_seen = 0;
  int unsigned faults_seen = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [BASE_W-1:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(6, 40);
  endfunction

  function automatic int unsigned eff_granule();
    return (cfg_gran >= GRAN_64K) ? 2 : int'(cfg_gran);
  endfunction

  function automatic int unsigned va_shift(input logic [1:0] lvl);
    int unsigned g;
    g = eff_granule();
    return (12 + 2 * g) + (9 + 2 * g) * (3 - int'(lvl));
  endfunction

  function automatic logic [ADDR_W-1:0] va_index_mask();
    case (eff_granule())
      0: return 64'h1ff;
      1: return 64'h7ff;
      default: return 64'h1fff;
    endcase
  endfunction

  function automatic logic [1:0] start_level();
    int unsigned g, width, page, q;
    g = eff_granule();
    width = 64 - int'(cfg_txsz);
    page = 12 + 2 * g;
    if (width <= page) return LEVEL_LAST;
    q = (width - page - 1) / (9 + 2 * g);
    return (q >= 3) ? 2'd0 : 2'(3 - q);
  endfunction

  function automatic void queue_read();
    res_t r;
    logic [ADDR_W-1:0] idx;
    idx = (walk_va >> va_shift(walk_lvl)) & va_index_mask();
    r.result_kind = RES_READ;
    r.out_address = walk_table + (idx << 3);
    r.fault = 1'b0;
    r.at_level = walk_lvl;
    walk_results.push_back(r);
  endfunction

  function automatic void predict_walk(input in_item_t it);
    res_t r;
    logic [ADDR_W-1:0] oa, offmask;
    if (it.kind == KIND_TRANSLATE) begin
      walking = 1'b1;
      walk_va = it.virtual_address;
      walk_lvl = start_level();
      walk_table = {16'h0, cfg_base};
      queue_read();
      return;
    end
    if (!walking) return;
    r.result_kind = RES_DONE;
    r.at_level = walk_lvl;
    if (!it.descriptor[0]) begin
      walking = 1'b0;
      r.out_address = FAULT_ADDR;
      r.fault = 1'b1;
      walk_results.push_back(r);
      return;
    end
    oa = it.descriptor & OA_FIELD;
    if (!it.descriptor[1] || walk_lvl == LEVEL_LAST) begin
      offmask = (64'd1 << va_shift(walk_lvl)) - 64'd1;
      walking = 1'b0;
      r.out_address = oa + (walk_va & offmask);
      r.fault = 1'b0;
      walk_results.push_back(r);
      return;
    end
    walk_table = oa;
    walk_lvl = walk_lvl + 2'd1;
    queue_read();
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    errors++;
    if (errors <= MAX_PRINTS) begin
      $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    end
  endtask

  task automatic check_result();
    res_t got, want;
    got.result_kind = walk_out.result_kind;
    got.out_address = walk_out.out_address;
    got.fault = walk_out.fault;
    got.at_level = walk_out.at_level;
    if (walk_results.size() == 0) begin
      flag_mismatch("unexpected result", got.out_address, '0);
      return;
    end
    want = walk_results.pop_front();
    checked++;
    if (want.result_kind == RES_READ) reads_seen++;
    else if (want.fault) faults_seen++;
    else leaves_seen++;
    if (got.result_kind !== want.result_kind) begin
      flag_mismatch("result_kind", 64'(got.result_kind), 64'(want.result_kind));
    end
    if (got.out_address !== want.out_address) begin
      flag_mismatch("out_address", got.out_address, want.out_address);
    end
    if (got.fault !== want.fault) begin
      flag_mismatch("fault", 64'(got.fault), 64'(want.fault));
    end
    if (got.at_level !== want.at_level) begin
      flag_mismatch("at_level", 64'(got.at_level), 64'(want.at_level));
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      walk_in.valid <= 1'b0;
    end else begin
      if (walk_in.valid && walk_in.ready) begin
        predict_walk(on_wire);
        accepted++;
      end
      if (!walk_in.valid || walk_in.ready) begin
        if (drain_marks.size() != 0 && accepted >= drain_marks[0] &&
            walk_results.size() == 0) begin
          void'(drain_marks.pop_front());
        end
        if (drain_marks.size() != 0 && accepted >= drain_marks[0]) begin
          walk_in.valid <= 1'b0;
        end else if (send_gap != 0) begin
          send_gap--;
          walk_in.valid <= 1'b0;
        end else if (walk_items.size() != 0) begin
          on_wire = walk_items.pop_front();
          walk_in.valid <= 1'b1;
          walk_in.kind <= on_wire.kind;
          walk_in.virtual_address <= on_wire.virtual_address;
          walk_in.descriptor <= on_wire.descriptor;
          send_gap = (!calm && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        end else begin
          walk_in.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      walk_out.ready <= 1'b0;
    end else begin
      if (walk_out.valid && walk_out.ready) check_result();
      if (take_stall != 0) begin
        take_stall--;
        walk_out.ready <= 1'b0;
      end else begin
        walk_out.ready <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) take_stall = pick_gap();
      end
    end
  end

  function automatic logic [63:0] make_desc(input desc_form_e form);
    logic [63:0] d;
    d = rand64();
    case (form)
      DESC_TABLE: d[1:0] = 2'b11;
      DESC_BLOCK: d[1:0] = 2'b01;
      default: d[0] = 1'b0;
    endcase
    return d;
  endfunction

  function automatic void push_translate(input logic [63:0] va);
    in_item_t it;
    it.kind = KIND_TRANSLATE;
    it.virtual_address = va;
    it.descriptor = rand64();
    walk_items.push_back(it);
    queued++;
  endfunction

  function automatic void push_descriptor(input logic [63:0] d);
    in_item_t it;
    it.kind = KIND_RESPONSE;
    it.virtual_address = rand64();
    it.descriptor = d;
    walk_items.push_back(it);
    queued++;
  endfunction

  function automatic void queue_directed();
    push_descriptor(64'h3);
    push_translate(64'h0);
    repeat (4) push_descriptor(FAULT_ADDR);
    push_descriptor(rand64());
    push_translate(FAULT_ADDR);
    push_descriptor(64'h0);
    push_translate(FAULT_ADDR);
    push_descriptor(64'hffff_ffff_ffff_fffd);
    push_translate(64'h0123_4567_89ab_cdef);
    push_descriptor(make_desc(DESC_TABLE));
    push_translate(64'hfedc_ba98_7654_3210);
    push_descriptor(make_desc(DESC_TABLE));
    push_descriptor(make_desc(DESC_BLOCK));
    push_translate(rand64());
    repeat (3) push_descriptor(make_desc(DESC_TABLE));
    push_descriptor(64'h1);
    push_translate(rand64());
    push_descriptor(make_desc(DESC_TABLE));
    push_descriptor(64'h2);
  endfunction

  // mostly well-formed walks; some restarted, overlong or preceded by stray responses
  function automatic void queue_walks(input int unsigned count);
    int unsigned made, depth, tables, r;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 99) < 8) push_descriptor(rand64());
      push_translate(rand64());
      made++;
      depth = 3 - int'(start_level());
      r = $urandom_range(0, 99);
      if (r < 70) tables = $urandom_range(0, depth);
      else if (r < 85) tables = depth;
      else tables = depth + $urandom_range(1, 2);
      repeat (tables) push_descriptor(make_desc(DESC_TABLE));
      made += tables;
      r = $urandom_range(0, 99);
      if (r >= 12) begin
        push_descriptor(make_desc((r < 35) ? DESC_INVALID : DESC_BLOCK));
        made++;
      end
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TABLE_BASE: cfg_base = data;
      CFG_GRANULE: cfg_gran = data[1:0];
      CFG_TXSZ: cfg_txsz = data[5:0];
      default: ;
    endcase
  endtask

  task automatic set_tables(input logic [BASE_W-1:0] base, input logic [1:0] gran,
                            input logic [5:0] txsz);
    write_reg(CFG_TABLE_BASE, base);
    write_reg(CFG_GRANULE, CFG_DATA_W'(gran));
    write_reg(CFG_TXSZ, CFG_DATA_W'(txsz));
  endtask

  task automatic settle();
    while (accepted != queued || walk_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    res_t left;
    logic [5:0] txsz;
    walk_in.valid = 1'b0;
    walk_in.kind = KIND_TRANSLATE;
    walk_in.virtual_address = '0;
    walk_in.descriptor = '0;
    walk_out.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    queue_directed();
    settle();
    for (int p = 0; p < PHASES; p++) begin
      txsz = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) :
                                           6'($urandom_range(16, 39));
      case (p)
        0: set_tables(48'hffff_ffff_ffff, GRAN_RESERVED, 6'd63);
        1: set_tables(48'h0, GRAN_16K, 6'd0);
        2: set_tables(rand48(), GRAN_64K, 6'd39);
        3: set_tables(rand48(), GRAN_4K, 6'd39);
        4: set_tables(rand48(), GRAN_64K, TXSZ_RESET);
        default: set_tables(rand48(), 2'($urandom_range(0, 3)), txsz);
      endcase
      calm = (p % 4 == 1);
      queue_walks(PHASE_ITEMS / 2);
      if (p % 4 == 2) drain_marks.push_back(queued);
      queue_walks(PHASE_ITEMS / 2);
      settle();
    end
    repeat (10) @(posedge clk_i);
    while (walk_results.size() != 0) begin
      left = walk_results.pop_front();
      flag_mismatch("missing result", '0, left.out_address);
    end
    $display("%0d transfers in, %0d results checked over %0d table settings",
             accepted, checked, PHASES + 1);
    $display("%0d descriptor reads, %0d translations, %0d faults",
             reads_seen, leaves_seen, faults_seen);
    if (errors == 0) begin
      $display("translation_table_walker_unit_test OK");
    end else begin
      $display("translation_table_walker_unit_test NOT OK");
    end
    $finish;
  end

  initial begin
    while (cycles < RUN_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("translation_table_walker_unit_test NOT OK");
    $finish;
  end

endmodule
